>>> hdl/circle_point_generator_core_defines.svh
// Assertion macros shared by the circle point generator modules.
`ifndef CIRCLE_POINT_GENERATOR_CORE_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_CORE_DEFINES_SVH

// cond must never hold at a clock edge outside reset
`define CPG_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define CPG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define CPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/cpg_pkg.sv
// Types and constants shared by the circle point generator.
`timescale 1ns / 1ps
package cpg_pkg;

	localparam int COORD_WIDTH = 16;

	// wide enough for every intermediate of one step
	localparam int CALC_W = 21;
	// pixel adder width, never narrower than the widest operand
	localparam int SUM_W = (COORD_WIDTH > 19) ? COORD_WIDTH : 19;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW+1)'(QUEUE_DEPTH);
	localparam logic [QUEUE_AW-1:0] PTR_ONE = QUEUE_AW'(1);
	localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_AW:0] CNT_ONE = (QUEUE_AW+1)'(1);

	localparam logic signed [CALC_W-1:0] C_ZERO = CALC_W'(0);
	localparam logic signed [CALC_W-1:0] C_ONE = CALC_W'(1);
	localparam logic signed [CALC_W-1:0] C_TWO = CALC_W'(2);

	typedef enum logic {
		REQ_START   = 1'b0,
		REQ_ADVANCE = 1'b1
	} req_type_t;

	typedef enum logic {
		ALG_MIDPOINT  = 1'b0,
		ALG_BRESENHAM = 1'b1
	} alg_t;

	// one point group handed from the front to the back
	typedef struct packed {
		logic signed [14:0] origin_x;
		logic signed [14:0] origin_y;
		logic [14:0]        off_x;
		logic signed [15:0] off_y;
		logic               four_way;
		logic               done;
	} desc_t;

endpackage

>>> hdl/cpg_front.sv
// Front end: accepts requests, runs one circle step, emits a group descriptor.
`timescale 1ns / 1ps
module cpg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_alg,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 req_type,
	input  logic signed [14:0]   center_x,
	input  logic signed [14:0]   center_y,
	input  logic [13:0]          radius,
	input  logic                 q_full,
	output logic                 push,
	output cpg_pkg::desc_t       desc
);

	logic               alg_q;
	logic               active_q;
	logic [14:0]        off_x_q;
	logic signed [15:0] off_y_q;
	logic signed [17:0] dec_q;
	logic signed [14:0] origin_x_q;
	logic signed [14:0] origin_y_q;

	logic                      accept;
	logic                      start;
	logic                      bres;
	logic [14:0]               x0;
	logic signed [15:0]        y0;
	logic signed [17:0]        d0;
	logic signed [cpg_pkg::CALC_W-1:0] rw;
	logic signed [cpg_pkg::CALC_W-1:0] dstart;
	logic signed [cpg_pkg::CALC_W-1:0] xw, yw, dw;
	logic signed [cpg_pkg::CALC_W-1:0] mx, my, md;
	logic signed [cpg_pkg::CALC_W-1:0] bx, by, bd;
	logic signed [cpg_pkg::CALC_W-1:0] t1, t2;
	logic                      diag;
	logic [14:0]               nx;
	logic signed [15:0]        ny;
	logic signed [17:0]        nd;
	logic                      done;

	assign req_stall = q_full;
	assign accept    = req_valid && !req_stall;
	assign start     = (req_type == cpg_pkg::REQ_START);
	assign bres      = (alg_q == cpg_pkg::ALG_BRESENHAM);
	assign push      = accept && (start || active_q);

	// starting state, or the held state on an advance
	always_comb begin
		rw = {{(cpg_pkg::CALC_W-14){1'b0}}, radius};
		if (bres) begin
			dstart = cpg_pkg::C_TWO - (rw <<< 1);
		end else begin
			dstart = cpg_pkg::C_ONE - rw;
		end
		if (start) begin
			x0 = '0;
			y0 = {2'b00, radius};
			d0 = dstart[17:0];
		end else begin
			x0 = off_x_q;
			y0 = off_y_q;
			d0 = dec_q;
		end
		xw = {{(cpg_pkg::CALC_W-15){1'b0}}, x0};
		yw = {{(cpg_pkg::CALC_W-16){y0[15]}}, y0};
		dw = {{(cpg_pkg::CALC_W-18){d0[17]}}, d0};
	end

	// midpoint step
	always_comb begin
		mx = xw + cpg_pkg::C_ONE;
		if (dw < cpg_pkg::C_ZERO) begin
			my = yw;
			md = dw + (mx <<< 1) + cpg_pkg::C_ONE;
		end else begin
			my = yw - cpg_pkg::C_ONE;
			md = dw + ((mx - my) <<< 1) + cpg_pkg::C_ONE;
		end
	end

	// Bresenham step with horizontal, vertical or diagonal move
	always_comb begin
		bx   = xw;
		by   = yw;
		bd   = dw;
		diag = 1'b0;
		t1   = ((dw + yw) <<< 1) - cpg_pkg::C_ONE;
		t2   = ((dw - xw) <<< 1) - cpg_pkg::C_ONE;
		if (dw < cpg_pkg::C_ZERO) begin
			if (t1 <= cpg_pkg::C_ZERO) begin
				bx = xw + cpg_pkg::C_ONE;
				bd = dw + (bx <<< 1) + cpg_pkg::C_ONE;
			end else begin
				diag = 1'b1;
			end
		end else if (dw > cpg_pkg::C_ZERO) begin
			if (t2 <= cpg_pkg::C_ZERO) begin
				diag = 1'b1;
			end else begin
				by = yw - cpg_pkg::C_ONE;
				bd = dw + cpg_pkg::C_ONE - (by <<< 1);
			end
		end else begin
			diag = 1'b1;
		end
		if (diag) begin
			bx = bx + cpg_pkg::C_ONE;
			by = by - cpg_pkg::C_ONE;
			bd = bd + ((bx - by + cpg_pkg::C_ONE) <<< 1);
		end
	end

	// new stored state, emitted offset and completion
	always_comb begin
		if (bres) begin
			nx = bx[14:0];
			ny = by[15:0];
			nd = bd[17:0];
		end else if (start) begin
			nx = x0;
			ny = y0;
			nd = d0;
		end else begin
			nx = mx[14:0];
			ny = my[15:0];
			nd = md[17:0];
		end
		if (bres) begin
			done = ny[15];
		end else begin
			done = !(ny > $signed({1'b0, nx}));
		end
		desc.origin_x = start ? center_x : origin_x_q;
		desc.origin_y = start ? center_y : origin_y_q;
		desc.off_x    = bres ? x0 : nx;
		desc.off_y    = bres ? y0 : ny;
		desc.four_way = bres;
		desc.done     = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q      <= cpg_pkg::ALG_MIDPOINT;
			active_q   <= 1'b0;
			off_x_q    <= '0;
			off_y_q    <= '0;
			dec_q      <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else begin
			if (cfg_we) begin
				alg_q <= cfg_alg;
			end
			if (push) begin
				active_q   <= !done;
				off_x_q    <= nx;
				off_y_q    <= ny;
				dec_q      <= nd;
				origin_x_q <= desc.origin_x;
				origin_y_q <= desc.origin_y;
			end
		end
	end

endmodule

>>> hdl/cpg_queue.sv
// Short descriptor queue between the front and back ends.
`timescale 1ns / 1ps
`include "circle_point_generator_core_defines.svh"
module cpg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cpg_pkg::desc_t wr_desc,
	output logic           full,
	input  logic           pop,
	output cpg_pkg::desc_t head,
	output logic           head_valid
);

	cpg_pkg::desc_t                entries_q [cpg_pkg::QUEUE_DEPTH];
	logic [cpg_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [cpg_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [cpg_pkg::QUEUE_AW:0]    count_q;
	logic                          empty;

	assign full       = (count_q == cpg_pkg::QUEUE_FULL);
	assign empty      = (count_q == '0);
	assign head_valid = !empty;
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == cpg_pkg::PTR_LAST) ? '0 : wr_ptr_q + cpg_pkg::PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == cpg_pkg::PTR_LAST) ? '0 : rd_ptr_q + cpg_pkg::PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + cpg_pkg::CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - cpg_pkg::CNT_ONE;
			end
		end
	end

	`CPG_ASSERT_NEVER(a_push_full, push && full, "push into a full queue")
	`CPG_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from an empty queue")

endmodule

>>> hdl/cpg_back.sv
// Back end: expands one group descriptor into its pixels, one per cycle while pix_stall is low.
`timescale 1ns / 1ps
`include "circle_point_generator_core_defines.svh"
module cpg_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cpg_pkg::desc_t                        head,
	input  logic                                  head_valid,
	output logic                                  pop,
	output logic                                  pix_valid,
	input  logic                                  pix_stall,
	output logic signed [cpg_pkg::COORD_WIDTH-1:0] pixel_x,
	output logic signed [cpg_pkg::COORD_WIDTH-1:0] pixel_y,
	output logic                                  last,
	output logic                                  done_res
);

	logic [2:0]                         idx_q;
	logic                               pix_valid_q;
	logic signed [cpg_pkg::COORD_WIDTH-1:0] pixel_x_q;
	logic signed [cpg_pkg::COORD_WIDTH-1:0] pixel_y_q;
	logic                               last_q;
	logic                               done_q;

	logic                              load;
	logic                              is_last;
	logic signed [17:0]                xs, ys, nxs, nys;
	logic signed [17:0]                a, b;
	logic signed [cpg_pkg::SUM_W-1:0]  sum_x, sum_y;

	assign load    = !pix_valid_q || !pix_stall;
	assign is_last = head.four_way ? (idx_q == 3'd3) : (idx_q == 3'd7);
	assign pop     = load && head_valid && is_last;

	// symmetric offset for the current pixel of the group
	always_comb begin
		xs  = {3'b000, head.off_x};
		ys  = {{2{head.off_y[15]}}, head.off_y};
		nxs = -xs;
		nys = -ys;
		a   = xs;
		b   = ys;
		if (head.four_way) begin
			case (idx_q)
				3'd0: begin a = xs;  b = ys;  end
				3'd1: begin a = nxs; b = ys;  end
				3'd2: begin a = xs;  b = nys; end
				3'd3: begin a = nxs; b = nys; end
				default: begin a = xs; b = ys; end
			endcase
		end else begin
			case (idx_q)
				3'd0: begin a = xs;  b = ys;  end
				3'd1: begin a = ys;  b = xs;  end
				3'd2: begin a = ys;  b = nxs; end
				3'd3: begin a = xs;  b = nys; end
				3'd4: begin a = nxs; b = nys; end
				3'd5: begin a = nys; b = nxs; end
				3'd6: begin a = nys; b = xs;  end
				3'd7: begin a = nxs; b = ys;  end
				default: begin a = xs; b = ys; end
			endcase
		end
		sum_x = {{(cpg_pkg::SUM_W-15){head.origin_x[14]}}, head.origin_x}
			+ {{(cpg_pkg::SUM_W-18){a[17]}}, a};
		sum_y = {{(cpg_pkg::SUM_W-18){b[17]}}, b}
			- {{(cpg_pkg::SUM_W-15){head.origin_y[14]}}, head.origin_y};
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			pixel_x_q <= sum_x[cpg_pkg::COORD_WIDTH-1:0];
			pixel_y_q <= sum_y[cpg_pkg::COORD_WIDTH-1:0];
			last_q    <= is_last;
			done_q    <= head.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pix_valid_q <= 1'b0;
		end else if (load) begin
			pix_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	assign pix_valid = pix_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign last      = last_q;
	assign done_res  = done_q;

	`CPG_ASSERT_IMPL(a_idx_range, head_valid && head.four_way, idx_q < 3'd4, "four-way index past group end")
	`CPG_ASSERT_NEXT(a_idx_rewind, pop, idx_q == 3'd0, "index not rewound after group end")

endmodule

>>> hdl/circle_point_generator_core.sv
// A step's descriptor is registered in the queue, then its pixels in the back end's output register.
// The output register gives one pixel per cycle while pix_stall is low; a step yields
// 8 pixels in midpoint mode and 4 in Bresenham mode; an idle advance queues nothing.
// A four-entry descriptor queue lets the front run ahead of the pixel output.
// Reset (arst_n low): no circle active, algorithm midpoint, queue and output empty.
`timescale 1ns / 1ps
module circle_point_generator_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  algorithm,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  req_type,
	input  logic signed [14:0]                    center_x,
	input  logic signed [14:0]                    center_y,
	input  logic [13:0]                           radius,
	output logic                                  pix_valid,
	input  logic                                  pix_stall,
	output logic signed [cpg_pkg::COORD_WIDTH-1:0] pixel_x,
	output logic signed [cpg_pkg::COORD_WIDTH-1:0] pixel_y,
	output logic                                  last,
	output logic                                  done_res
);

	logic           cfg_we;
	logic           q_full;
	logic           push;
	logic           pop;
	logic           head_valid;
	cpg_pkg::desc_t wr_desc;
	cpg_pkg::desc_t head;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	cpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_alg   (algorithm),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.q_full    (q_full),
		.push      (push),
		.desc      (wr_desc)
	);

	cpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_desc    (wr_desc),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	cpg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last       (last),
		.done_res   (done_res)
	);

endmodule
